@@ src/mch_pkg.sv @@
package mch_pkg;

  localparam int SampleBits  = 16;
  localparam int SumBits     = SampleBits + 1;
  localparam int AngleBits   = 16;
  localparam int CordicSteps = 16;
  localparam int CalBits     = 16;
  localparam int CordW       = CalBits + 16 + 2;
  localparam int NumW        = SumBits + 2;
  localparam int QuoBits     = 17;

  localparam logic [3:0] CfgMount  = 4'd0;
  localparam logic [3:0] CfgDecl   = 4'd1;
  localparam logic [3:0] CfgWindow = 4'd2;
  localparam logic [3:0] CfgReady  = 4'd3;

  localparam logic signed [10:0] NotReadyDeg = -11'sd999;

  typedef struct packed {
    logic signed [15:0] sample_a_x;
    logic signed [15:0] sample_a_y;
    logic signed [15:0] sample_a_z;
    logic signed [15:0] sample_b_x;
    logic signed [15:0] sample_b_y;
    logic signed [15:0] sample_b_z;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] heading_deg;
    logic signed [15:0] cal_forward;
    logic signed [15:0] cal_left;
    logic signed [15:0] cal_up;
    logic               calibrating;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, update bounds
    logic div_start; // start divide of axis
    logic [1:0] axis;
    logic div_step;
    logic div_done;  // store quotient of axis
    logic remap;     // remap, start cordic
    logic cord_step;
    logic finish;    // heading, fill output
  } cmd_t;

  typedef struct packed {
    logic not_ready;
  } sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      r = 32'd0;
      unique case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // mounting: source axes and negate flags, fwd/left/up
  function automatic logic [11:0] mount_map(input logic [3:0] mo);
    logic [11:0] r;
    begin
      unique case (mo)
        4'd0:  r = {2'd0, 2'd1, 2'd2, 3'b011, 3'b000};
        4'd1:  r = {2'd0, 2'd1, 2'd2, 3'b000, 3'b000};
        4'd2:  r = {2'd0, 2'd2, 2'd1, 3'b010, 3'b000};
        4'd3:  r = {2'd0, 2'd2, 2'd1, 3'b001, 3'b000};
        4'd4:  r = {2'd1, 2'd0, 2'd2, 3'b010, 3'b000};
        4'd5:  r = {2'd1, 2'd0, 2'd2, 3'b001, 3'b000};
        4'd6:  r = {2'd1, 2'd2, 2'd0, 3'b011, 3'b000};
        4'd7:  r = {2'd1, 2'd2, 2'd0, 3'b000, 3'b000};
        4'd9:  r = {2'd2, 2'd0, 2'd1, 3'b000, 3'b000};
        4'd10: r = {2'd2, 2'd1, 2'd0, 3'b011, 3'b000};
        4'd11: r = {2'd2, 2'd1, 2'd0, 3'b000, 3'b000};
        default: r = {2'd2, 2'd0, 2'd1, 3'b011, 3'b000};
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/mch_ctrl.sv @@
module mch_ctrl import mch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DSTRT = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MAP   = 7'b0001000,
    S_CORD  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] axis, axis_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.not_ready) state_next = S_FIN;
          else begin
            axis_next  = 2'd0;
            state_next = S_DSTRT;
          end
        end
      end
      S_DSTRT: begin
        cmd.div_start = 1'b1;
        cnt_next      = 5'(QuoBits - 1);
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt - 5'd1;
        if (cnt == 5'd0) begin
          cmd.div_done = 1'b1;
          if (axis == 2'd2) begin
            state_next = S_MAP;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = S_DSTRT;
          end
        end
      end
      // all three axes stored: remap and load the CORDIC
      S_MAP: begin
        cmd.remap  = 1'b1;
        cnt_next   = 5'd0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(CordicSteps - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
    end
  end

endmodule

@@ src/mch_dp.sv @@
module mch_dp import mch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  in_item_t    in_item,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_item
);

  // configuration
  logic [3:0]  mount;
  logic [15:0] decl;
  logic [31:0] win_ms;
  logic        ready_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount <= 4'd8; decl <= 16'd2295; win_ms <= 32'd60000; ready_cfg <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMount:  mount <= cfg_data[3:0];
        CfgDecl:   decl <= cfg_data[15:0];
        CfgWindow: win_ms <= cfg_data;
        CfgReady:  ready_cfg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sts.not_ready = ~ready_cfg;

  // sums and bounds
  logic signed [SumBits-1:0] sum [3];
  logic signed [SumBits-1:0] smin [3];
  logic signed [SumBits-1:0] smax [3];
  logic signed [SumBits-1:0] in_sum [3];
  logic        started;
  logic [31:0] start_ms;
  logic        calib;
  logic        calib_now;
  logic [31:0] base_ms;

  assign in_sum[0] = SumBits'(in_item.sample_a_x) + SumBits'(in_item.sample_b_x);
  assign in_sum[1] = SumBits'(in_item.sample_a_y) + SumBits'(in_item.sample_b_y);
  assign in_sum[2] = SumBits'(in_item.sample_a_z) + SumBits'(in_item.sample_b_z);
  assign base_ms   = started ? start_ms : in_item.now_ms;
  assign calib_now = (in_item.now_ms - base_ms) < win_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      start_ms <= '0;
      for (int k = 0; k < 3; k++) begin
        smin[k] <= {1'b0, {(SumBits-1){1'b1}}};
        smax[k] <= {1'b1, {(SumBits-1){1'b0}}};
      end
    end else if (cmd.load && ready_cfg) begin
      started  <= 1'b1;
      start_ms <= base_ms;
      if (calib_now) begin
        for (int k = 0; k < 3; k++) begin
          if (in_sum[k] < smin[k]) smin[k] <= in_sum[k];
          if (in_sum[k] > smax[k]) smax[k] <= in_sum[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) sum[k] <= in_sum[k];
      calib <= calib_now & ready_cfg;
    end
  end

  // restoring divider: q = (|num|*16384 + span) / (2*span)
  // upper dividend bits preload the remainder; if they already reach the
  // divisor the quotient is too large and saturates
  localparam int DivW = NumW + 15;
  logic signed [NumW-1:0] num_s, span_s;
  logic [DivW-1:0]  dividend;
  logic [DivW-1:0]  div_full;
  logic [DivW-QuoBits-1:0] hi_bits;
  logic [NumW:0]    divisor;
  logic [NumW:0]    divisor_in;
  logic [DivW:0]    rem;
  logic [QuoBits-1:0] quo;
  logic             neg_num, zero_span, ovf;
  logic [NumW-1:0]  mag;
  logic [DivW:0]    rem_sh;
  logic [DivW:0]    trial;

  assign num_s  = (NumW'(sum[cmd.axis]) <<< 1) - NumW'(smax[cmd.axis]) - NumW'(smin[cmd.axis]);
  assign span_s = NumW'(smax[cmd.axis]) - NumW'(smin[cmd.axis]);
  assign mag    = num_s[NumW-1] ? NumW'(-num_s) : NumW'(num_s);
  assign div_full   = (DivW'(mag) << 14) + DivW'(span_s);
  assign hi_bits    = div_full[DivW-1:QuoBits];
  assign divisor_in = (NumW+1)'(span_s) << 1;
  assign rem_sh = {rem[DivW-1:0], dividend[DivW-1]};
  assign trial  = rem_sh - (DivW+1)'(divisor);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend  <= {div_full[QuoBits-1:0], {(DivW-QuoBits){1'b0}}};
      divisor   <= divisor_in;
      rem       <= (DivW+1)'(hi_bits);
      quo       <= '0;
      neg_num   <= num_s[NumW-1];
      zero_span <= (span_s <= 0);
      ovf       <= ((NumW+1)'(hi_bits) >= divisor_in);
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      if (!trial[DivW]) begin
        rem <= trial;
        quo <= {quo[QuoBits-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QuoBits-2:0], 1'b0};
      end
    end
  end

  // quotient after the last step, saturated
  logic [QuoBits-1:0] quo_fin;
  logic [15:0]        qsat;
  logic signed [15:0] cal_v;
  logic signed [15:0] cal [3];

  assign quo_fin = {quo[QuoBits-2:0], ~trial[DivW]};
  assign qsat    = (ovf || (quo_fin > QuoBits'(32768))) ? 16'h8000 : quo_fin[15:0];
  always_comb begin
    if (zero_span) cal_v = '0;
    else if (neg_num) cal_v = -$signed(qsat);
    else if (qsat == 16'h8000) cal_v = 16'sd32767;
    else cal_v = $signed(qsat);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_done) cal[cmd.axis] <= cal_v;
  end

  // remap and CORDIC
  logic [11:0] mm;
  logic signed [15:0] frame [3];
  logic signed [15:0] fr_next [3];
  logic signed [CordW-1:0] cx, cy, cx_sh, cy_sh;
  logic [31:0] cz;
  logic [4:0]  it;

  assign mm = mount_map(mount);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [15:0] v;
      v = cal[mm[11-2*k -: 2]];
      if (mm[5-k]) v = (v == -16'sd32768) ? 16'sd32767 : -v;
      fr_next[k] = v;
    end
  end

  assign cx_sh = cx >>> it;
  assign cy_sh = cy >>> it;

  always_ff @(posedge clk) begin
    if (cmd.remap) begin
      for (int k = 0; k < 3; k++) frame[k] <= fr_next[k];
      it <= '0;
      if (fr_next[0] < 0) begin
        cx <= -(CordW'(fr_next[0]) <<< 16);
        cy <= -(CordW'(fr_next[1]) <<< 16);
        cz <= 32'h8000_0000;
      end else begin
        cx <= CordW'(fr_next[0]) <<< 16;
        cy <= CordW'(fr_next[1]) <<< 16;
        cz <= '0;
      end
    end else if (cmd.cord_step) begin
      it <= it + 5'd1;
      if (cy > 0) begin
        cx <= cx + cy_sh; cy <= cy - cx_sh; cz <= cz + atan_turn(it);
      end else begin
        cx <= cx - cy_sh; cy <= cy + cx_sh; cz <= cz - atan_turn(it);
      end
    end
  end

  // heading and output register
  logic [31:0] ang;
  logic [AngleBits-1:0] a;
  logic [AngleBits+8:0] prod;
  logic zero_vec;

  assign zero_vec = (frame[0] == 0) && (frame[1] == 0);
  assign ang  = (zero_vec ? 32'd0 : cz) + {decl, 16'd0};
  assign a    = AngleBits'((ang + (32'd1 << (31 - AngleBits))) >> (32 - AngleBits));
  assign prod = (AngleBits+9)'(a) * (AngleBits+9)'(360);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!ready_cfg) begin
        out_item <= '{heading_deg: NotReadyDeg, cal_forward: '0, cal_left: '0,
                      cal_up: '0, calibrating: 1'b0};
      end else begin
        out_item.heading_deg <= 11'(prod >> AngleBits);
        out_item.cal_forward <= frame[0];
        out_item.cal_left    <= frame[1];
        out_item.cal_up      <= frame[2];
        out_item.calibrating <= calib;
      end
    end
  end

endmodule

@@ src/magnetometer_calibrated_heading.sv @@
// Each item is loaded; if ready, the shared bit-serial divider normalises the
// three axes in turn, one quotient bit per step, the frame is remapped, the
// CORDIC runs 16 steps and the heading is registered; if not ready, the item
// goes straight to the output register. No new item is taken before the output is read.
// Synchronous active-high reset: registers to their documented defaults,
// calibration window not yet opened, bounds at their extremes; no clearing pass.
module magnetometer_calibrated_heading import mch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  mch_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  mch_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_item, .cmd, .sts, .out_item
  );

endmodule

@@ bench/tb_magnetometer_calibrated_heading.sv @@
`timescale 1ns / 100ps

module tb_magnetometer_calibrated_heading;
  import mch_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;

  magnetometer_calibrated_heading dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and calibration state
  logic [3:0]         mdl_mount;
  logic signed [15:0] mdl_decl;
  logic [31:0]        mdl_window;
  logic               mdl_ready;
  logic               mdl_started;
  logic [31:0]        mdl_start_ms;
  longint             mdl_min [3];
  longint             mdl_max [3];

  out_item_t heading_q[$];
  int        n_err;
  bit        free_run;

  // directed stimulus: item, expected-known flag, expected value
  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t res;
  } vec_t;

  localparam longint AtanTurn [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  // axis source (0 x, 1 y, 2 z) and negate flags per mounting code
  localparam int SrcF [12] = '{0,0,0,0,1,1,1,1,2,2,2,2};
  localparam int SrcL [12] = '{1,1,2,2,0,0,2,2,0,0,1,1};
  localparam int SrcU [12] = '{2,2,1,1,2,2,0,0,1,1,0,0};
  localparam bit NegL [12] = '{1,0,1,0,1,0,1,0,1,0,1,0};
  localparam bit NegU [12] = '{1,0,0,1,0,1,1,0,1,0,1,0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint fdiv_shift(longint v, int s);
    if (v < 0) return -(((-v) - 1) >>> s) - 1;
    return v >>> s;
  endfunction

  function automatic longint norm_axis(longint s, longint lo, longint hi);
    longint span, num, mag, q;
    span = hi - lo;
    num = 2 * s - hi - lo;
    if (span <= 0) return 0;
    mag = num < 0 ? -num : num;
    q = (mag * 16384 + span) / (2 * span);
    if (q > 32768) q = 32768;
    q = num < 0 ? -q : q;
    if (q > 32767) q = 32767;
    return q;
  endfunction

  function automatic logic [31:0] vector_angle(longint yv, longint xv);
    longint x, y, t;
    logic [31:0] z;
    x = xv * 65536;
    y = yv * 65536;
    z = '0;
    if (xv == 0 && yv == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        t = x + fdiv_shift(y, i);
        y = y - fdiv_shift(x, i);
        z = z + 32'(AtanTurn[i]);
      end else begin
        t = x - fdiv_shift(y, i);
        y = y + fdiv_shift(x, i);
        z = z - 32'(AtanTurn[i]);
      end
      x = t;
    end
    return z;
  endfunction

  function automatic longint flip(longint v, bit neg);
    if (!neg) return v;
    return (-v > 32767) ? 32767 : -v;
  endfunction

  // expected heading result for one item; updates predictor state
  function automatic out_item_t predict_heading(in_item_t it);
    out_item_t r;
    longint sm [3];
    longint cal [3];
    longint fw, lf;
    logic [31:0] ang, a;
    bit calib;
    int mo;
    r = '0;
    if (!mdl_ready) begin
      r.heading_deg = NotReadyDeg;
      return r;
    end
    sm[0] = longint'(it.sample_a_x) + longint'(it.sample_b_x);
    sm[1] = longint'(it.sample_a_y) + longint'(it.sample_b_y);
    sm[2] = longint'(it.sample_a_z) + longint'(it.sample_b_z);
    if (!mdl_started) begin
      mdl_started = 1'b1;
      mdl_start_ms = it.now_ms;
    end
    calib = (it.now_ms - mdl_start_ms) < mdl_window;
    for (int k = 0; k < 3; k++) begin
      if (calib) begin
        if (sm[k] < mdl_min[k]) mdl_min[k] = sm[k];
        if (sm[k] > mdl_max[k]) mdl_max[k] = sm[k];
      end
      cal[k] = norm_axis(sm[k], mdl_min[k], mdl_max[k]);
    end
    mo = mdl_mount < 12 ? int'(mdl_mount) : 8;
    fw = cal[SrcF[mo]];
    lf = flip(cal[SrcL[mo]], NegL[mo]);
    ang = vector_angle(lf, fw) + {mdl_decl, 16'h0000};
    a = ((ang + 32'h8000) >> 16) & 32'hFFFF;
    r.heading_deg = 11'((longint'(a) * 360) >> 16);
    r.cal_forward = 16'(fw);
    r.cal_left = 16'(lf);
    r.cal_up = 16'(flip(cal[SrcU[mo]], NegU[mo]));
    r.calibrating = calib;
    return r;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgMount:  mdl_mount = val[3:0];
      CfgDecl:   mdl_decl = val[15:0];
      CfgWindow: mdl_window = val;
      CfgReady:  mdl_ready = val[0];
      default: ;
    endcase
  endtask

  // drop valid, then wait until idle with margin for the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // valid stays up after an item unless the sender idles or drains
  task automatic send_item(in_item_t it, bit known, out_item_t res);
    out_item_t p;
    if (!free_run) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    p = predict_heading(it);
    if (known && p != res) begin
      $error("directed row: predictor gives %h, table %h", p, res);
      n_err++;
    end
    heading_q.push_back(p);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic in_item_t rand_item(logic [31:0] t, int mag);
    in_item_t it;
    it.sample_a_x = 16'($signed($urandom_range(2 * mag)) - mag);
    it.sample_a_y = 16'($signed($urandom_range(2 * mag)) - mag);
    it.sample_a_z = 16'($signed($urandom_range(2 * mag)) - mag);
    it.sample_b_x = 16'($signed($urandom_range(2 * mag)) - mag);
    it.sample_b_y = 16'($signed($urandom_range(2 * mag)) - mag);
    it.sample_b_z = 16'($signed($urandom_range(2 * mag)) - mag);
    it.now_ms = t;
    return it;
  endfunction

  // result checking
  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (heading_q.size() == 0) begin
          $error("unexpected item %h", out_item);
          n_err++;
        end else begin
          e = heading_q.pop_front();
          if (out_item.heading_deg !== e.heading_deg) begin
            $error("heading_deg exp %0d got %0d", e.heading_deg, out_item.heading_deg);
            n_err++;
          end
          if (out_item.cal_forward !== e.cal_forward) begin
            $error("cal_forward exp %0d got %0d", e.cal_forward, out_item.cal_forward);
            n_err++;
          end
          if (out_item.cal_left !== e.cal_left) begin
            $error("cal_left exp %0d got %0d", e.cal_left, out_item.cal_left);
            n_err++;
          end
          if (out_item.cal_up !== e.cal_up) begin
            $error("cal_up exp %0d got %0d", e.cal_up, out_item.cal_up);
            n_err++;
          end
          if (out_item.calibrating !== e.calibrating) begin
            $error("calibrating exp %0d got %0d", e.calibrating, out_item.calibrating);
            n_err++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= free_run ? 1'b1 : ($urandom_range(99) >= 32);
  end

  initial begin
    vec_t dirv[$];
    vec_t v;
    out_item_t nr;
    logic [31:0] t;
    int mag;
    n_err = 0;
    free_run = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CfgMount;
    cfg_data = '0;
    mdl_mount = 4'd8;
    mdl_decl = 16'sd2295;
    mdl_window = 32'd60000;
    mdl_ready = 1'b0;
    mdl_started = 1'b0;
    mdl_start_ms = '0;
    for (int k = 0; k < 3; k++) begin
      mdl_min[k] = 65535;
      mdl_max[k] = -65536;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // not ready after reset: fixed answer
    nr = '0;
    nr.heading_deg = NotReadyDeg;
    v.known = 1'b1;
    v.res = nr;
    v.item = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF};
    dirv.push_back(v);
    v.item = '0;
    dirv.push_back(v);
    foreach (dirv[i]) send_item(dirv[i].item, dirv[i].known, dirv[i].res);
    drain();

    // ready: window opens; extremes, zero vector, negation of most negative
    write_reg(CfgReady, 32'd1);
    dirv.delete();
    v.known = 1'b0;
    v.item = '0;
    dirv.push_back(v);
    v.item = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'd10};
    dirv.push_back(v);
    v.item = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd20};
    dirv.push_back(v);
    v.item = {16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh0000, 32'd30};
    dirv.push_back(v);
    v.item = {16'sh1234, 16'shF00F, 16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shC3C3, 32'd59999};
    dirv.push_back(v);
    v.item = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd60000};
    dirv.push_back(v);
    v.item = {16'sh0001, 16'shFFFF, 16'sh0002, 16'sh0000, 16'sh0000, 16'sh0000, 32'hFFFF_FFFF};
    dirv.push_back(v);
    foreach (dirv[i]) send_item(dirv[i].item, dirv[i].known, dirv[i].res);
    drain();
    // every mounting code, unused ones too
    for (int m = 0; m < 16; m++) begin
      write_reg(CfgMount, 32'(m));
      send_item({16'sh0100, 16'sh0200, 16'shFF00, 16'sh0010, 16'shFE00, 16'sh0300, 32'd5},
                1'b0, nr);
      drain();
    end

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgMount, 32'($urandom_range(15)));
      case (ph)
        0: write_reg(CfgDecl, 32'h8000);
        1: write_reg(CfgDecl, 32'h7FFF);
        default: write_reg(CfgDecl, $urandom);
      endcase
      case (ph)
        0: write_reg(CfgWindow, 32'd0);
        1: write_reg(CfgWindow, 32'hFFFF_FFFF);
        default: write_reg(CfgWindow, $urandom_range(2000, 50));
      endcase
      write_reg(CfgReady, (ph == 3) ? 32'd0 : 32'd1);
      free_run = (ph == 5);
      t = $urandom;
      for (int n = 0; n < 210; n++) begin
        t = t + $urandom_range(20);
        mag = ($urandom_range(9) == 0) ? 32768 : $urandom_range(32767, 1);
        send_item(rand_item(t, mag), 1'b0, nr);
        if (n == 100) drain();
      end
      free_run = 1'b0;
      drain();
    end

    drain();
    if (n_err == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ magnetometer_calibrated_heading.f @@
src/mch_pkg.sv
src/mch_ctrl.sv
src/mch_dp.sv
src/magnetometer_calibrated_heading.sv
bench/tb_magnetometer_calibrated_heading.sv
